/* rtl/tqha_pkg.sv */
package tqha_pkg;

  localparam int unsigned POOLS            = 8;
  localparam int unsigned QUERIES_PER_POOL = 64;

  localparam int unsigned SLOT_W  = (QUERIES_PER_POOL > 1) ? $clog2(QUERIES_PER_POOL) : 1;
  localparam int unsigned POOL_W  = (POOLS > 1) ? $clog2(POOLS) : 1;
  localparam int unsigned ENTRY_W = POOL_W + SLOT_W;
  // Table and stack rows are addressed as {pool, slot}; slot offsets past the
  // pool size are never used.
  localparam int unsigned ENTRIES = POOLS << SLOT_W;
  localparam int unsigned CNT_W   = $clog2(QUERIES_PER_POOL + 1);

  localparam int unsigned OP_W       = 2;
  localparam int unsigned POOL_IDX_W = 8;
  localparam int unsigned HANDLE_W   = 32;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned POOL_OUT_W = 3;
  localparam int unsigned SLOT_OUT_W = 6;

  localparam int unsigned QUEUE_DEPTH = 2;

  typedef enum logic [OP_W-1:0] {
    OP_ALLOC   = 2'd0,
    OP_RELEASE = 2'd1,
    OP_RESOLVE = 2'd2,
    OP_RESOLVE_ALT = 2'd3
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK     = 2'd0,
    STAT_POOL   = 2'd1,
    STAT_HANDLE = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    CMD_ALLOC,
    CMD_RELEASE,
    CMD_RESOLVE,
    CMD_BADPOOL
  } cmd_e;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_STACK,
    S_PROBE,
    S_SEARCH
  } state_e;

  typedef struct packed {
    cmd_e                kind;
    logic [POOL_W-1:0]   pool;
    logic [HANDLE_W-1:0] handle;
  } cmd_t;

  typedef struct packed {
    logic                valid;
    logic [HANDLE_W-1:0] handle;
  } tbl_word_t;

endpackage

/* rtl/tqha_if.sv */
interface tqha_in_if;
  logic                              valid;
  logic                              ready;
  logic [tqha_pkg::OP_W-1:0]         op;
  logic [tqha_pkg::POOL_IDX_W-1:0]   pool_index;
  logic [tqha_pkg::HANDLE_W-1:0]     handle;

  modport source (output valid, op, pool_index, handle, input ready);
  modport sink   (input valid, op, pool_index, handle, output ready);
endinterface

interface tqha_out_if;
  logic                              valid;
  logic                              ready;
  logic [tqha_pkg::STATUS_W-1:0]     status;
  logic [tqha_pkg::HANDLE_W-1:0]     handle_out;
  logic [tqha_pkg::POOL_OUT_W-1:0]   pool_out;
  logic [tqha_pkg::SLOT_OUT_W-1:0]   slot_out;

  modport source (output valid, status, handle_out, pool_out, slot_out, input ready);
  modport sink   (input valid, status, handle_out, pool_out, slot_out, output ready);
endinterface

/* rtl/timestamp_query_handle_allocator_core.sv */
// A bad or exhausted pool and handle zero are answered when popped, without a table scan.
// Release and resolve scan the handle table at one entry per cycle, up to a hit or the last entry.
// Allocate pops the pool stack, then scans once per candidate handle until one is unused.
// The back end handles one item at a time, bounded by the table scan through one read port.
// Reset is asynchronous, active low; afterward a clearing pass over all ENTRIES (512) rows
// initializes the table and stacks, and no item is accepted until it is done.
module timestamp_query_handle_allocator_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  tqha_in_if.sink     in_i,
  tqha_out_if.source  out_o
);

  logic            push, full, pop, q_valid, busy;
  tqha_pkg::cmd_t  push_cmd, head_cmd;

  tqha_front u_front (
    .in_i   (in_i),
    .busy_i (busy),
    .full_i (full),
    .push_o (push),
    .cmd_o  (push_cmd)
  );

  tqha_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .cmd_o   (head_cmd)
  );

  tqha_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_cmd_i   (head_cmd),
    .pop_o     (pop),
    .busy_o    (busy),
    .out_o     (out_o)
  );

endmodule

/* rtl/tqha_front.sv */
module tqha_front (
  tqha_in_if.sink          in_i,
  input  logic             busy_i,
  input  logic             full_i,
  output logic             push_o,
  output tqha_pkg::cmd_t   cmd_o
);

  tqha_pkg::op_e op;

  assign op        = tqha_pkg::op_e'(in_i.op);
  assign in_i.ready = !full_i && !busy_i;
  assign push_o    = in_i.valid && in_i.ready;

  always_comb begin
    cmd_o.pool   = in_i.pool_index[tqha_pkg::POOL_W-1:0];
    cmd_o.handle = in_i.handle;
    priority if (op == tqha_pkg::OP_ALLOC) begin
      if ({1'b0, in_i.pool_index} >= (tqha_pkg::POOL_IDX_W+1)'(tqha_pkg::POOLS)) begin
        cmd_o.kind = tqha_pkg::CMD_BADPOOL;
      end else begin
        cmd_o.kind = tqha_pkg::CMD_ALLOC;
      end
    end else if (op == tqha_pkg::OP_RELEASE) begin
      cmd_o.kind = tqha_pkg::CMD_RELEASE;
    end else begin
      // Both remaining opcodes resolve.
      cmd_o.kind = tqha_pkg::CMD_RESOLVE;
    end
  end

endmodule

/* rtl/tqha_queue.sv */
module tqha_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  tqha_pkg::cmd_t   cmd_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output tqha_pkg::cmd_t   cmd_o
);

  localparam int unsigned PtrW = (tqha_pkg::QUEUE_DEPTH > 1) ? $clog2(tqha_pkg::QUEUE_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(tqha_pkg::QUEUE_DEPTH + 1);

  tqha_pkg::cmd_t    slots_q [tqha_pkg::QUEUE_DEPTH];
  logic [PtrW-1:0]   wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0]   cnt_q, cnt_d;

  assign full_o  = (cnt_q == CntW'(tqha_pkg::QUEUE_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign cmd_o   = slots_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == PtrW'(tqha_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (pop_i) begin
      rd_d = (rd_q == PtrW'(tqha_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wr_q] <= cmd_i;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) pop_i |-> valid_o)
    else $error("queue popped while empty");
  assert property (@(posedge clk_i) disable iff (!rst_ni) push_i |-> !full_o)
    else $error("queue pushed while full");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (push_i && !pop_i) |=> (cnt_q == $past(cnt_q) + 1'b1))
    else $error("queue count lost a push");

endmodule

/* rtl/tqha_back.sv */
module tqha_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             q_valid_i,
  input  tqha_pkg::cmd_t   q_cmd_i,
  output logic             pop_o,
  output logic             busy_o,
  tqha_out_if.source       out_o
);

  localparam int unsigned EW = tqha_pkg::ENTRY_W;
  localparam int unsigned SW = tqha_pkg::SLOT_W;
  localparam int unsigned PW = tqha_pkg::POOL_W;
  localparam int unsigned CW = tqha_pkg::CNT_W;
  localparam int unsigned HW = tqha_pkg::HANDLE_W;
  localparam logic [EW-1:0] LastAddr = EW'(tqha_pkg::ENTRIES - 1);

  tqha_pkg::state_e    state_q, state_d;
  tqha_pkg::cmd_t      cmd_q;
  logic [EW-1:0]       addr_q, addr_d;
  logic                issue_q, issue_d;
  logic                rd_vld_q, rd_vld_d;
  logic [EW-1:0]       rd_idx_q;
  logic [HW-1:0]       key_q, next_handle_q;
  logic [SW-1:0]       slot_q;
  logic [CW-1:0]       count_q [tqha_pkg::POOLS];

  tqha_pkg::tbl_word_t tbl_mem [tqha_pkg::ENTRIES];
  logic [SW-1:0]       stk_mem [tqha_pkg::ENTRIES];
  tqha_pkg::tbl_word_t tbl_rd_q;
  logic [SW-1:0]       stk_rd_q;

  logic                out_valid_q;
  logic [tqha_pkg::STATUS_W-1:0]   out_status_q;
  logic [HW-1:0]                   out_handle_q;
  logic [tqha_pkg::POOL_OUT_W-1:0] out_pool_q;
  logic [tqha_pkg::SLOT_OUT_W-1:0] out_slot_q;

  logic                hit, last, done;
  logic [PW-1:0]       cnt_pool, rd_pool;
  logic [SW-1:0]       rd_slot;
  logic [CW-1:0]       cnt;
  logic                tbl_we, stk_we, stk_re;
  logic [EW-1:0]       tbl_waddr, stk_waddr, stk_raddr;
  tqha_pkg::tbl_word_t tbl_wdata;
  logic [SW-1:0]       stk_wdata;
  logic                commit_alloc, commit_release, cnt_dec, cnt_inc;
  logic                load_out;
  logic [tqha_pkg::STATUS_W-1:0]   res_status;
  logic [HW-1:0]                   res_handle;
  logic [tqha_pkg::POOL_OUT_W-1:0] res_pool;
  logic [tqha_pkg::SLOT_OUT_W-1:0] res_slot;

  assign rd_pool  = rd_idx_q[EW-1:SW];
  assign rd_slot  = rd_idx_q[SW-1:0];
  assign hit      = rd_vld_q && tbl_rd_q.valid && (tbl_rd_q.handle == key_q);
  assign last     = rd_vld_q && (rd_idx_q == LastAddr);
  assign done     = hit || last;
  assign cnt_pool = (state_q == tqha_pkg::S_IDLE) ? q_cmd_i.pool :
                    (cmd_q.kind == tqha_pkg::CMD_RELEASE) ? rd_pool : cmd_q.pool;
  assign cnt      = count_q[cnt_pool];

  assign busy_o       = (state_q == tqha_pkg::S_INIT);
  assign pop_o        = (state_q == tqha_pkg::S_IDLE) && q_valid_i && !out_valid_q;
  assign out_o.valid      = out_valid_q;
  assign out_o.status     = out_status_q;
  assign out_o.handle_out = out_handle_q;
  assign out_o.pool_out   = out_pool_q;
  assign out_o.slot_out   = out_slot_q;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      tqha_pkg::S_INIT: begin
        if (addr_q == LastAddr) state_d = tqha_pkg::S_IDLE;
      end
      tqha_pkg::S_IDLE: begin
        if (pop_o) begin
          unique case (q_cmd_i.kind)
            tqha_pkg::CMD_ALLOC: begin
              if (cnt != '0) state_d = tqha_pkg::S_STACK;
            end
            tqha_pkg::CMD_RELEASE, tqha_pkg::CMD_RESOLVE: begin
              if (q_cmd_i.handle != '0) state_d = tqha_pkg::S_SEARCH;
            end
            default: state_d = tqha_pkg::S_IDLE;
          endcase
        end
      end
      tqha_pkg::S_STACK: state_d = tqha_pkg::S_PROBE;
      tqha_pkg::S_PROBE: begin
        if (next_handle_q != '0) state_d = tqha_pkg::S_SEARCH;
      end
      tqha_pkg::S_SEARCH: begin
        if (done) begin
          state_d = (hit && cmd_q.kind == tqha_pkg::CMD_ALLOC) ? tqha_pkg::S_PROBE
                                                                : tqha_pkg::S_IDLE;
        end
      end
      default: state_d = tqha_pkg::S_INIT;
    endcase
  end

  // Datapath controls.
  always_comb begin
    addr_d         = addr_q;
    issue_d        = 1'b0;
    rd_vld_d       = 1'b0;
    tbl_we         = 1'b0;
    tbl_waddr      = addr_q;
    tbl_wdata      = '0;
    stk_we         = 1'b0;
    stk_waddr      = addr_q;
    stk_wdata      = SW'(tqha_pkg::QUERIES_PER_POOL - 1) - addr_q[SW-1:0];
    stk_re         = 1'b0;
    stk_raddr      = {q_cmd_i.pool, SW'(cnt - 1'b1)};
    commit_alloc   = 1'b0;
    commit_release = 1'b0;
    load_out       = 1'b0;
    res_status     = tqha_pkg::STAT_OK;
    res_handle     = '0;
    res_pool       = '0;
    res_slot       = '0;
    unique case (state_q)
      tqha_pkg::S_INIT: begin
        // Clearing pass: every table row invalid, every stack in reset order.
        tbl_we = 1'b1;
        stk_we = 1'b1;
        addr_d = addr_q + 1'b1;
      end
      tqha_pkg::S_IDLE: begin
        addr_d  = '0;
        issue_d = 1'b1;
        if (pop_o) begin
          unique case (q_cmd_i.kind)
            tqha_pkg::CMD_ALLOC: begin
              stk_re = (cnt != '0);
              if (cnt == '0) begin
                load_out   = 1'b1;
                res_status = tqha_pkg::STAT_POOL;
              end
            end
            tqha_pkg::CMD_RELEASE, tqha_pkg::CMD_RESOLVE: begin
              if (q_cmd_i.handle == '0) begin
                load_out   = 1'b1;
                res_status = tqha_pkg::STAT_HANDLE;
              end
            end
            default: begin
              load_out   = 1'b1;
              res_status = tqha_pkg::STAT_POOL;
            end
          endcase
        end
      end
      tqha_pkg::S_STACK: begin
        addr_d  = '0;
        issue_d = 1'b1;
      end
      tqha_pkg::S_PROBE: begin
        addr_d  = '0;
        issue_d = 1'b1;
      end
      tqha_pkg::S_SEARCH: begin
        if (!done && issue_q) begin
          rd_vld_d = 1'b1;
          addr_d   = addr_q + 1'b1;
          issue_d  = (addr_q != LastAddr);
        end
        if (done) begin
          unique case (cmd_q.kind)
            tqha_pkg::CMD_ALLOC: begin
              if (!hit) begin
                commit_alloc = 1'b1;
                tbl_we       = 1'b1;
                tbl_waddr    = {cmd_q.pool, slot_q};
                tbl_wdata    = '{valid: 1'b1, handle: key_q};
                load_out     = 1'b1;
                res_handle   = key_q;
                res_pool     = tqha_pkg::POOL_OUT_W'(cmd_q.pool);
                res_slot     = tqha_pkg::SLOT_OUT_W'(slot_q);
              end
            end
            tqha_pkg::CMD_RELEASE: begin
              load_out = 1'b1;
              if (hit) begin
                commit_release = 1'b1;
                tbl_we         = 1'b1;
                tbl_waddr      = rd_idx_q;
                stk_we         = (cnt < CW'(tqha_pkg::QUERIES_PER_POOL));
                stk_waddr      = {rd_pool, SW'(cnt)};
                stk_wdata      = rd_slot;
              end else begin
                res_status = tqha_pkg::STAT_HANDLE;
              end
            end
            default: begin
              load_out = 1'b1;
              if (hit) begin
                res_pool = tqha_pkg::POOL_OUT_W'(rd_pool);
                res_slot = tqha_pkg::SLOT_OUT_W'(rd_slot);
              end else begin
                res_status = tqha_pkg::STAT_HANDLE;
              end
            end
          endcase
        end
      end
      default: addr_d = '0;
    endcase
  end

  assign cnt_dec = commit_alloc;
  assign cnt_inc = commit_release && (cnt < CW'(tqha_pkg::QUERIES_PER_POOL));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= tqha_pkg::S_INIT;
      addr_q        <= '0;
      issue_q       <= 1'b0;
      rd_vld_q      <= 1'b0;
      next_handle_q <= HW'(1);
      out_valid_q   <= 1'b0;
      for (int p = 0; p < int'(tqha_pkg::POOLS); p++) begin
        count_q[p] <= CW'(tqha_pkg::QUERIES_PER_POOL);
      end
    end else begin
      state_q  <= state_d;
      addr_q   <= addr_d;
      issue_q  <= issue_d;
      rd_vld_q <= rd_vld_d;
      if (state_q == tqha_pkg::S_PROBE) begin
        next_handle_q <= next_handle_q + 1'b1;
      end
      if (cnt_dec) count_q[cnt_pool] <= cnt - 1'b1;
      if (cnt_inc) count_q[cnt_pool] <= cnt + 1'b1;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rd_idx_q <= addr_q;
    if (pop_o) begin
      cmd_q <= q_cmd_i;
      key_q <= q_cmd_i.handle;
    end
    if (state_q == tqha_pkg::S_STACK) begin
      slot_q <= stk_rd_q;
    end
    if (state_q == tqha_pkg::S_PROBE) begin
      key_q <= next_handle_q;
    end
    if (load_out) begin
      out_status_q <= res_status;
      out_handle_q <= res_handle;
      out_pool_q   <= res_pool;
      out_slot_q   <= res_slot;
    end
  end

  // Handle table and free-slot stacks, registered reads.
  always_ff @(posedge clk_i) begin
    if (tbl_we) tbl_mem[tbl_waddr] <= tbl_wdata;
    tbl_rd_q <= tbl_mem[addr_q];
  end

  always_ff @(posedge clk_i) begin
    if (stk_we) stk_mem[stk_waddr] <= stk_wdata;
    if (stk_re) stk_rd_q <= stk_mem[stk_raddr];
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (state_q == tqha_pkg::S_SEARCH) |-> !out_valid_q)
    else $error("result register occupied during a search");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   rd_vld_q |-> $past(state_q == tqha_pkg::S_SEARCH))
    else $error("table compare without a search read");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (state_q == tqha_pkg::S_SEARCH) |-> (key_q != '0))
    else $error("search for handle zero");

endmodule
